// ===== sv/bia_pkg.sv =====
// Shared constants, codes and control/status types for the bitmap id allocator.
`timescale 1ns / 1ps

package bia_pkg;

  localparam int ID_SPACE  = 8192;
  localparam int WORD_BITS = 32;
  localparam int ID_W      = $clog2(ID_SPACE);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = ID_W - BIT_W;
  localparam int MAP_WORDS = ID_SPACE / WORD_BITS;
  localparam int REG_W     = ID_W + 1;

  localparam logic [REG_W-1:0] MIN_ID_RST   = REG_W'(300);
  localparam logic [REG_W-1:0] ID_LIMIT_RST = REG_W'(5000);

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_MIN_ID   = 1'b0,
    REG_ID_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic    take_in;
    logic    scan_step;
    logic    commit;
    logic    res_set;
    status_t res_code;
    logic    load_res;
  } cmd_t;

  typedef struct packed {
    logic is_rel;
    logic in_range;
    logic win_empty;
    logic hit;
    logic last_word;
  } sts_t;

endpackage

// ===== sv/bitmap_id_allocator.sv =====
// Top level of the lowest-free-first bitmap identifier allocator.
// From accept to result: an in-range release updates its word, an allocate scans n 32-bit words
// (one read per cycle, n at most 256); an out-of-range release or empty window skips the scan.
// Throughput: items do not overlap; the next item is taken once the result is
// parked in the output register, even while that result is still stalled.
// Reset: bitmap reads as all free at once (per-word valid bits), min_id 300, limit 5000.
`timescale 1ns / 1ps

module bitmap_id_allocator
  import bia_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [ID_W-1:0]  in_release_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  out_granted_id,
  output logic [1:0]       out_status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bia_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (in_func),
    .in_release_id  (in_release_id),
    .cmd            (cmd),
    .sts            (sts),
    .out_granted_id (out_granted_id),
    .out_status     (out_status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_res |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled item");

  a_commit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> cmd.res_set && !cmd.scan_step)
    else $error("bitmap write while scan continues");

  a_zero_id_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ALLOCATED) |-> (out_granted_id == '0))
    else $error("nonzero id on a result that granted nothing");

endmodule

// ===== sv/bia_ctrl.sv =====
// Sequencer for the allocator: accepts items, steps the word scan, hands off results.
`timescale 1ns / 1ps

module bia_ctrl
  import bia_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            state_nxt = sts.in_range ? S_EVAL : S_HOLD;
          end else begin
            state_nxt = sts.win_empty ? S_HOLD : S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (sts.is_rel || sts.hit || sts.last_word) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_code = ST_EXHAUSTED;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (in_func && !sts.in_range) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_IGNORED;
          end else if (!in_func && sts.win_empty) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_EXHAUSTED;
          end
        end
      end
      S_EVAL: begin
        if (sts.is_rel) begin
          cmd.commit   = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_RELEASED;
        end else if (sts.hit) begin
          cmd.commit   = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_ALLOCATED;
        end else if (sts.last_word) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_EXHAUSTED;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HOLD: begin
        cmd.load_res = out_free;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_res || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/bia_dp.sv =====
// Datapath: config registers, used-id bitmap memory, free-bit search and result registers.
`timescale 1ns / 1ps

module bia_dp
  import bia_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             in_func,
  input  logic [ID_W-1:0]  in_release_id,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [ID_W-1:0]  out_granted_id,
  output logic [1:0]       out_status
);

  logic [REG_W-1:0]     min_id_r, min_id_nxt;
  logic [REG_W-1:0]     id_limit_r, id_limit_nxt;
  logic [REG_W-1:0]     lim, lim_m1;
  logic [WADDR_W-1:0]   first_word, last_word;
  logic [BIT_W-1:0]     min_bit, last_bit;

  logic                 func_r;
  logic [ID_W-1:0]      rid_r;
  logic [WADDR_W-1:0]   addr_r, addr_nxt;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvld_r;
  logic [WORD_BITS-1:0] word, lo_mask, hi_mask, free, low1, wdata;
  logic [BIT_W-1:0]     hit_bit;

  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  status_t              res_st_r;
  logic [ID_W-1:0]      out_id_r;
  status_t              out_st_r;

  // configuration
  always_comb begin
    min_id_nxt   = min_id_r;
    id_limit_nxt = id_limit_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_ID:   min_id_nxt   = cfg_data;
        REG_ID_LIMIT: id_limit_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_id_r   <= MIN_ID_RST;
      id_limit_r <= ID_LIMIT_RST;
    end else begin
      min_id_r   <= min_id_nxt;
      id_limit_r <= id_limit_nxt;
    end
  end

  // search window
  assign lim        = (id_limit_r > REG_W'(ID_SPACE)) ? REG_W'(ID_SPACE) : id_limit_r;
  assign lim_m1     = lim - REG_W'(1);
  assign first_word = min_id_r[ID_W-1:BIT_W];
  assign min_bit    = min_id_r[BIT_W-1:0];
  assign last_word  = lim_m1[ID_W-1:BIT_W];
  assign last_bit   = lim_m1[BIT_W-1:0];

  // item registers and word address
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      func_r <= in_func;
      rid_r  <= in_release_id;
    end
    addr_r <= addr_nxt;
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.take_in) begin
      addr_nxt = in_func ? in_release_id[ID_W-1:BIT_W] : first_word;
    end else if (cmd.scan_step) begin
      addr_nxt = addr_r + WADDR_W'(1);
    end
  end

  // bitmap memory; a word never written reads as all free
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      map_mem[addr_r] <= wdata;
    end
    rdata_r <= map_mem[addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        vld_r[addr_r] <= 1'b1;
      end
      rvld_r <= vld_r[addr_nxt];
    end
  end

  assign word    = rvld_r ? rdata_r : '0;
  assign lo_mask = (addr_r == first_word) ? ({WORD_BITS{1'b1}} << min_bit) : '1;
  assign hi_mask = (addr_r == last_word) ?
                   ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit)) : '1;
  assign free    = ~word & lo_mask & hi_mask;
  assign low1    = free & (~free + WORD_BITS'(1));

  always_comb begin
    hit_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low1[i]) hit_bit = hit_bit | BIT_W'(i);
    end
  end

  assign wdata = func_r ? (word & ~(WORD_BITS'(1) << rid_r[BIT_W-1:0]))
                        : (word | low1);

  // status to the sequencer
  always_comb begin
    sts.is_rel    = func_r;
    sts.in_range  = ({1'b0, in_release_id} >= min_id_r) && ({1'b0, in_release_id} < lim);
    sts.win_empty = (min_id_r >= lim);
    sts.hit       = (free != '0);
    sts.last_word = (addr_r == last_word);
  end

  // result and output registers
  assign res_id_nxt = (cmd.res_code == ST_ALLOCATED) ? {addr_r, hit_bit} : '0;

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_id_r <= res_id_nxt;
      res_st_r <= cmd.res_code;
    end
    if (cmd.load_res) begin
      out_id_r <= res_id_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_granted_id = out_id_r;
  assign out_status     = out_st_r;

endmodule

// ===== verif/tb_bitmap_id_allocator.sv =====
// Self-checking testbench for bitmap_id_allocator: directed and random allocate/release items
`timescale 1ns / 1ps

module tb_bitmap_id_allocator;
  import bia_pkg::*;

  localparam int   CYCLE_LIMIT = 1000000;
  localparam logic OP_ALLOC    = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] granted;
    status_t         status;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_func = 1'b0;
  logic [ID_W-1:0]  in_release_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ID_W-1:0]  out_granted_id;
  logic [1:0]       out_status;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [0:0]       cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  // allocator state as seen by the predictor
  logic             id_used [ID_SPACE];
  logic [REG_W-1:0] win_lo = MIN_ID_RST;
  logic [REG_W-1:0] win_hi = ID_LIMIT_RST;

  reply_t           reply_q [$];
  logic [ID_W-1:0]  granted_pool [$];
  bit               no_idle = 1'b0;
  int               fail_cnt = 0;
  int               cycle_cnt = 0;
  int               out_hold = 0;
  int               out_gap;
  reply_t           want;

  bitmap_id_allocator DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic int eff_limit();
    return (win_hi < ID_SPACE) ? int'(win_hi) : ID_SPACE;
  endfunction

  function automatic reply_t predict_reply(input logic func, input logic [ID_W-1:0] rid);
    reply_t r;
    int     lim;
    r.granted = '0;
    r.status  = ST_EXHAUSTED;
    lim = eff_limit();
    if (func == OP_ALLOC) begin
      for (int i = int'(win_lo); i < lim; i++) begin
        if (!id_used[i]) begin
          id_used[i] = 1'b1;
          r.granted  = ID_W'(i);
          r.status   = ST_ALLOCATED;
          granted_pool.push_back(r.granted);
          break;
        end
      end
    end else if (rid >= win_lo && int'(rid) < lim) begin
      id_used[rid] = 1'b0;
      r.status     = ST_RELEASED;
    end else begin
      r.status = ST_IGNORED;
    end
    return r;
  endfunction

  task automatic send_req(input logic func, input logic [ID_W-1:0] rid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_release_id <= rid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reply_q.push_back(predict_reply(func, rid));
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_ID;
    cfg_data  <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_ID_LIMIT;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic test_reset_window();
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '1);
    send_req(OP_RELEASE, ID_W'(MIN_ID_RST));
    send_req(OP_RELEASE, ID_W'(MIN_ID_RST));
    send_req(OP_ALLOC, '0);
    send_req(OP_RELEASE, ID_W'(MIN_ID_RST - 1));
    send_req(OP_RELEASE, ID_W'(ID_LIMIT_RST));
    send_req(OP_RELEASE, ID_W'(ID_LIMIT_RST - 1));
    send_req(OP_RELEASE, '0);
    send_req(OP_RELEASE, '1);
  endtask

  task automatic test_empty_window();
    set_window('0, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_RELEASE, '0);
    set_window(ID_LIMIT_RST, MIN_ID_RST);
    send_req(OP_ALLOC, '1);
    send_req(OP_RELEASE, ID_W'(MIN_ID_RST));
  endtask

  task automatic test_limit_beyond_space();
    set_window(REG_W'(ID_SPACE - 2), '1);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_RELEASE, ID_W'(ID_SPACE - 1));
    send_req(OP_RELEASE, ID_W'(ID_SPACE - 3));
  endtask

  task automatic test_full_space();
    set_window('0, REG_W'(ID_SPACE));
    send_req(OP_ALLOC, '0);
    send_req(OP_RELEASE, '0);
    send_req(OP_RELEASE, ID_W'(ID_SPACE - 1));
  endtask

  task automatic test_random_traffic();
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    logic [ID_W-1:0]  rid;
    int               lim;
    int               pick;
    int               idx;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          lo = MIN_ID_RST;
          hi = ID_LIMIT_RST;
        end
        2: begin
          lo = '0;
          hi = REG_W'(ID_SPACE);
        end
        3: begin
          lo = REG_W'($urandom_range(ID_SPACE - 90, ID_SPACE - 1));
          hi = '1;
        end
        4: begin
          hi = REG_W'($urandom_range(0, ID_SPACE - 1));
          lo = hi + REG_W'($urandom_range(0, 100));
        end
        6: begin
          lo = REG_W'($urandom);
          hi = REG_W'($urandom);
        end
        8: begin
          lo = REG_W'(ID_SPACE - 1);
          hi = REG_W'(ID_SPACE);
        end
        default: begin
          lo = REG_W'($urandom_range(0, ID_SPACE - 1));
          hi = lo + REG_W'($urandom_range(1, 40));
        end
      endcase
      set_window(lo, hi);
      for (int n = 0; n < 50; n++) begin
        if (n % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
        lim  = eff_limit();
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_req(OP_ALLOC, ID_W'($urandom));
        end else begin
          if (pick < 8 && granted_pool.size() != 0) begin
            idx = $urandom_range(0, granted_pool.size() - 1);
            rid = granted_pool[idx];
            granted_pool.delete(idx);
          end else if (pick == 8 && int'(win_lo) < lim) begin
            rid = ID_W'($urandom_range(int'(win_lo), lim - 1));
          end else begin
            rid = ID_W'($urandom);
          end
          send_req(OP_RELEASE, rid);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected item: id %0d status %0d", out_granted_id, out_status);
        end else begin
          want = reply_q.pop_front();
          if (out_granted_id !== want.granted || out_status !== want.status) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected id %0d status %0d, got id %0d status %0d",
                       want.granted, want.status, out_granted_id, out_status);
          end
        end
        out_gap = pick_gap();
        out_hold  <= out_gap;
        out_stall <= (out_gap != 0);
      end else if (out_hold != 0) begin
        out_hold  <= out_hold - 1;
        out_stall <= (out_hold > 1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    foreach (id_used[i]) id_used[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_empty_window();
    test_limit_beyond_space();
    test_full_space();
    test_random_traffic();
    drain_replies();
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
